### design/spq_pkg.sv
package spq_pkg;

    localparam int VALUE_W   = 32;
    localparam int PRIO_IN_W = 16;
    localparam int STATUS_W  = 2;
    localparam int OCC_W     = 5;

    localparam logic MODE_POP = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_UNDERFLOW = 2'd1,
        ST_OVERFLOW  = 2'd2
    } t_status;

    typedef struct packed {
        logic    capture;
        logic    commit;
        logic    push_ok;
        logic    pop_ok;
        t_status status;
    } t_dp_cmd;

    typedef struct packed {
        logic pop_req;
        logic empty;
        logic full;
    } t_dp_stat;

endpackage

### design/spq_if.sv
interface spq_in_if import spq_pkg::*; ();
    logic                        valid;
    logic                        ready;
    logic                        mode;
    logic signed [VALUE_W-1:0]   value;
    logic signed [PRIO_IN_W-1:0] priority_req;

    modport source (output valid, mode, value, priority_req, input ready);
    modport sink   (input valid, mode, value, priority_req, output ready);
endinterface

interface spq_out_if import spq_pkg::*; ();
    logic                        valid;
    logic                        ready;
    logic [STATUS_W-1:0]         status;
    logic signed [VALUE_W-1:0]   out_value;
    logic signed [PRIO_IN_W-1:0] out_priority;
    logic [OCC_W-1:0]            occupancy;

    modport source (output valid, status, out_value, out_priority, occupancy, input ready);
    modport sink   (input valid, status, out_value, out_priority, occupancy, output ready);
endinterface

### design/spq_ctrl.sv
module spq_ctrl import spq_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    t_state r_state;
    logic   r_out_valid;

    assign o_in_ready  = (r_state == S_IDLE) && i_rst_n;
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_cmd         = '0;
        o_cmd.status  = ST_OK;
        o_cmd.capture = (r_state == S_IDLE) && i_in_valid && i_rst_n;
        o_cmd.commit  = (r_state == S_EXEC) && (!r_out_valid || i_out_ready);
        if (i_stat.pop_req) begin
            o_cmd.pop_ok = o_cmd.commit && !i_stat.empty;
            if (i_stat.empty) begin
                o_cmd.status = ST_UNDERFLOW;
            end
        end else begin
            o_cmd.push_ok = o_cmd.commit && !i_stat.full;
            if (i_stat.full) begin
                o_cmd.status = ST_OVERFLOW;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (o_cmd.commit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (o_cmd.capture) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (o_cmd.commit) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

### design/spq_datapath.sv
module spq_datapath import spq_pkg::*; #(
    parameter int QUEUE_DEPTH   = 16,
    parameter int PRIORITY_BITS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  t_dp_cmd                     i_cmd,
    output t_dp_stat                    o_stat,
    input  logic                        i_mode,
    input  logic signed [VALUE_W-1:0]   i_value,
    input  logic signed [PRIO_IN_W-1:0] i_priority_req,
    output logic [STATUS_W-1:0]         o_status,
    output logic signed [VALUE_W-1:0]   o_out_value,
    output logic signed [PRIO_IN_W-1:0] o_out_priority,
    output logic [OCC_W-1:0]            o_occupancy
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic                            r_mode;
    logic signed [VALUE_W-1:0]       r_value;
    logic signed [PRIORITY_BITS-1:0] r_prio;
    logic [CNT_W-1:0]                r_count;
    logic [CNT_W-1:0]                n_count;
    logic signed [VALUE_W-1:0]       r_slot_value [QUEUE_DEPTH];
    logic signed [PRIORITY_BITS-1:0] r_slot_prio  [QUEUE_DEPTH];
    logic [STATUS_W-1:0]             r_out_status;
    logic signed [VALUE_W-1:0]       r_out_value;
    logic signed [PRIO_IN_W-1:0]     r_out_priority;
    logic [OCC_W-1:0]                r_out_occ;

    logic [QUEUE_DEPTH-1:0] ge;
    logic [QUEUE_DEPTH-1:0] ge_prev;
    logic [31:0]            prio_in_ext;
    logic [31:0]            occ_ext;
    logic signed [31:0]     head_prio_ext;

    // The incoming priority keeps only its low bits, read as two's complement.
    assign prio_in_ext   = 32'($unsigned(i_priority_req));
    assign occ_ext       = 32'(n_count);
    assign head_prio_ext = 32'(r_slot_prio[0]);

    assign o_stat.pop_req = (r_mode == MODE_POP);
    assign o_stat.empty   = (r_count == '0);
    assign o_stat.full    = (r_count == CNT_W'(QUEUE_DEPTH));

    always_comb begin
        n_count = r_count;
        if (i_cmd.push_ok) begin
            n_count = r_count + CNT_W'(1);
        end else if (i_cmd.pop_ok) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    // Every cell compares its priority with the new entry at once. A held entry
    // of greater or equal priority stays; the first cell behind them takes the
    // new entry and the rest move one place toward the tail.
    for (genvar gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
        logic signed [VALUE_W-1:0]       up_value;
        logic signed [PRIORITY_BITS-1:0] up_prio;
        logic signed [VALUE_W-1:0]       down_value;
        logic signed [PRIORITY_BITS-1:0] down_prio;

        assign ge[gi] = (CNT_W'(gi) < r_count) && (r_slot_prio[gi] >= r_prio);

        if (gi == 0) begin : g_head
            assign ge_prev[gi] = 1'b1;
            assign down_value  = r_slot_value[gi];
            assign down_prio   = r_slot_prio[gi];
        end else begin : g_body
            assign ge_prev[gi] = ge[gi-1];
            assign down_value  = r_slot_value[gi-1];
            assign down_prio   = r_slot_prio[gi-1];
        end

        if (gi < QUEUE_DEPTH - 1) begin : g_inner
            assign up_value = r_slot_value[gi+1];
            assign up_prio  = r_slot_prio[gi+1];
        end else begin : g_tail
            assign up_value = r_slot_value[gi];
            assign up_prio  = r_slot_prio[gi];
        end

        always_ff @(posedge i_clk) begin
            if (i_cmd.pop_ok) begin
                r_slot_value[gi] <= up_value;
                r_slot_prio[gi]  <= up_prio;
            end else if (i_cmd.push_ok && !ge[gi]) begin
                if (ge_prev[gi]) begin
                    r_slot_value[gi] <= r_value;
                    r_slot_prio[gi]  <= r_prio;
                end else begin
                    r_slot_value[gi] <= down_value;
                    r_slot_prio[gi]  <= down_prio;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_mode  <= i_mode;
            r_value <= i_value;
            r_prio  <= prio_in_ext[PRIORITY_BITS-1:0];
        end
        if (i_cmd.commit) begin
            r_out_status <= i_cmd.status;
            r_out_occ    <= occ_ext[OCC_W-1:0];
            if (i_cmd.pop_ok) begin
                r_out_value    <= r_slot_value[0];
                r_out_priority <= head_prio_ext[PRIO_IN_W-1:0];
            end else begin
                r_out_value    <= '0;
                r_out_priority <= '0;
            end
        end
    end

    assign o_status       = r_out_status;
    assign o_out_value    = r_out_value;
    assign o_out_priority = r_out_priority;
    assign o_occupancy    = r_out_occ;

endmodule

### design/sorted_priority_queue.sv
// Sorted priority queue with one request channel and one result channel.
// A request carries mode (push or pop), value and priority_req; each request
// yields exactly one result with status, out_value, out_priority and the
// occupancy after the request.
// Entries sit in a row of cells sorted by priority, highest at the head. A push
// lands behind every entry of equal or higher priority, so equal priorities
// leave first in, first out. A pop returns the head. A pop on an empty queue
// reports underflow, a push to a full queue is dropped and reports overflow.
// The controller captures a request and then, once the output register is
// free or being taken, updates all cells in parallel and registers the result.
// The block accepts no new request until the previous one has been committed.
// The result sits in an output register: a new request is accepted while a
// result still waits, and when the receiver stalls the next request is held
// in the capture register until the output register frees.
// Reset empties the queue and drops any pending result; request ready stays
// low while reset is asserted.
module sorted_priority_queue import spq_pkg::*; #(
    parameter int QUEUE_DEPTH   = 16,
    parameter int PRIORITY_BITS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    spq_in_if.sink    i_req,
    spq_out_if.source o_rsp
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    spq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    spq_datapath #(
        .QUEUE_DEPTH   (QUEUE_DEPTH),
        .PRIORITY_BITS (PRIORITY_BITS)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_mode         (i_req.mode),
        .i_value        (i_req.value),
        .i_priority_req (i_req.priority_req),
        .o_status       (o_rsp.status),
        .o_out_value    (o_rsp.out_value),
        .o_out_priority (o_rsp.out_priority),
        .o_occupancy    (o_rsp.occupancy)
    );

endmodule

### design/spq_checker.sv
module spq_checker import spq_pkg::*; #(
    parameter int QUEUE_DEPTH = 16
) (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        i_in_ready,
    input logic                        i_out_valid,
    input logic                        i_out_ready,
    input logic [STATUS_W-1:0]         i_status,
    input logic signed [VALUE_W-1:0]   i_out_value,
    input logic signed [PRIO_IN_W-1:0] i_out_priority,
    input logic [OCC_W-1:0]            i_occupancy
);

    localparam logic [31:0] FULL_OCC = 32'(QUEUE_DEPTH);

    logic in_acc;

    assign in_acc = i_in_valid && i_in_ready;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("Result was withdrawn before it was taken.");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !i_in_ready)
        else $error("A second request was accepted while one was in work.");

    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(in_acc, 2))
        else $error("A result appeared without a request two cycles earlier.");

    a_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_status == ST_UNDERFLOW) |->
            (i_occupancy == '0) && (i_out_value == '0) && (i_out_priority == '0))
        else $error("Underflow reported on a queue that holds entries.");

    a_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_status == ST_OVERFLOW) |->
            (i_occupancy == FULL_OCC[OCC_W-1:0]) && (i_out_value == '0))
        else $error("Overflow reported on a queue that is not full.");

endmodule

bind sorted_priority_queue spq_checker #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
) u_spq_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_req.valid),
    .i_in_ready     (i_req.ready),
    .i_out_valid    (o_rsp.valid),
    .i_out_ready    (o_rsp.ready),
    .i_status       (o_rsp.status),
    .i_out_value    (o_rsp.out_value),
    .i_out_priority (o_rsp.out_priority),
    .i_occupancy    (o_rsp.occupancy)
);

### bench/sorted_priority_queue_tb.sv
`timescale 1ns / 1ps

module sorted_priority_queue_tb import spq_pkg::*; ();

    localparam int DEPTH      = 16;
    localparam int PBITS      = 16;
    localparam int N_RANDOM   = 500;
    localparam int MAX_CYCLES = 400000;
    localparam logic MODE_PUSH = ~MODE_POP;

    typedef struct packed {
        t_status                     status;
        logic signed [VALUE_W-1:0]   value;
        logic signed [PRIO_IN_W-1:0] prio;
        logic [OCC_W-1:0]            occ;
    } t_pq_result;

    class pq_scoreboard;
        logic signed [VALUE_W-1:0]   held_value[$];
        logic signed [PRIO_IN_W-1:0] held_prio[$];
        t_pq_result                  pending_results[$];
        int                          errors;

        function logic signed [PRIO_IN_W-1:0] fit_prio(logic signed [PRIO_IN_W-1:0] raw);
            logic signed [PRIO_IN_W-1:0] shifted;
            shifted = raw <<< (PRIO_IN_W - PBITS);
            return shifted >>> (PRIO_IN_W - PBITS);
        endfunction

        function void note_request(logic mode, logic signed [VALUE_W-1:0] v,
                                   logic signed [PRIO_IN_W-1:0] p);
            t_pq_result                  r;
            int                          pos;
            logic signed [PRIO_IN_W-1:0] key;
            r.status = ST_OK;
            r.value  = '0;
            r.prio   = '0;
            if (mode == MODE_POP) begin
                if (held_value.size() == 0) begin
                    r.status = ST_UNDERFLOW;
                end else begin
                    r.value = held_value.pop_front();
                    r.prio  = held_prio.pop_front();
                end
            end else if (held_value.size() >= DEPTH) begin
                r.status = ST_OVERFLOW;
            end else begin
                key = fit_prio(p);
                pos = 0;
                while (pos < held_prio.size() && held_prio[pos] >= key) pos++;
                held_value.insert(pos, v);
                held_prio.insert(pos, key);
            end
            r.occ = OCC_W'(held_value.size());
            pending_results.push_back(r);
        endfunction

        function void report(string field, longint exp_val, longint act_val);
            errors++;
            $display("%0t: mismatch on %s, expected %0d, actual %0d",
                     $time, field, exp_val, act_val);
        endfunction

        function void check_result(t_pq_result got);
            t_pq_result e;
            if (pending_results.size() == 0) begin
                errors++;
                $display("%0t: result with none expected, status %0d value %0d",
                         $time, got.status, got.value);
                return;
            end
            e = pending_results.pop_front();
            if (got.status !== e.status) report("status", e.status, got.status);
            if (got.value !== e.value) report("out_value", e.value, got.value);
            if (got.prio !== e.prio) report("out_priority", e.prio, got.prio);
            if (got.occ !== e.occ) report("occupancy", e.occ, got.occ);
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    bit   no_idle;
    int   cycles;

    pq_scoreboard sb;

    spq_in_if  req_if ();
    spq_out_if rsp_if ();

    sorted_priority_queue #(
        .QUEUE_DEPTH   (DEPTH),
        .PRIORITY_BITS (PBITS)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    always #5 i_clk = ~i_clk;

    function int pick_gap();
        int r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task send_request(logic mode, logic signed [VALUE_W-1:0] v,
                      logic signed [PRIO_IN_W-1:0] p);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid        <= 1'b1;
        req_if.mode         <= mode;
        req_if.value        <= v;
        req_if.priority_req <= p;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > MAX_CYCLES) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // The result is checked before the request of the same edge is noted.
    always @(posedge i_clk) begin
        if (i_rst_n && rsp_if.valid && rsp_if.ready)
            sb.check_result('{t_status'(rsp_if.status), rsp_if.out_value,
                              rsp_if.out_priority, rsp_if.occupancy});
        if (i_rst_n && req_if.valid && req_if.ready)
            sb.note_request(req_if.mode, req_if.value, req_if.priority_req);
    end

    initial begin
        int on_len;
        int off_len;
        rsp_if.ready = 1'b0;
        forever begin
            on_len = $urandom_range(1, 20);
            repeat (on_len) begin
                @(posedge i_clk);
                rsp_if.ready <= 1'b1;
            end
            off_len = pick_gap();
            repeat (off_len) begin
                @(posedge i_clk);
                rsp_if.ready <= 1'b0;
            end
        end
    end

    initial begin
        int   sent;
        int   kind;
        int   len;
        int   push_pct;
        logic mode;
        logic signed [VALUE_W-1:0]   v;
        logic signed [PRIO_IN_W-1:0] p;

        sb = new();
        i_clk               = 1'b0;
        i_rst_n             = 1'b0;
        no_idle             = 1'b0;
        cycles              = 0;
        req_if.valid        = 1'b0;
        req_if.mode         = MODE_PUSH;
        req_if.value        = '0;
        req_if.priority_req = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_request(MODE_POP, 32'h1234_5678, 16'sh0F0F);
        send_request(MODE_PUSH, 32'h7FFF_FFFF, 16'sh7FFF);
        send_request(MODE_PUSH, 32'h8000_0000, 16'sh8000);
        send_request(MODE_PUSH, 32'hFFFF_FFFF, 16'sh0000);
        send_request(MODE_PUSH, 32'h0000_0000, 16'sh0000);
        send_request(MODE_PUSH, 32'h0000_0001, 16'sh0000);
        send_request(MODE_PUSH, 32'h5555_5555, 16'shFFFF);
        send_request(MODE_PUSH, 32'hAAAA_AAAA, 16'sh0001);
        send_request(MODE_POP, 32'hFFFF_FFFF, 16'shFFFF);
        repeat (7) send_request(MODE_POP, '0, '0);
        send_request(MODE_PUSH, 32'd10, 16'sd5);
        send_request(MODE_PUSH, 32'd11, 16'sd5);
        send_request(MODE_PUSH, 32'd12, 16'sd5);
        send_request(MODE_PUSH, 32'd13, 16'sd6);
        repeat (4) send_request(MODE_POP, VALUE_W'($urandom), PRIO_IN_W'($urandom));

        // Phases lean toward filling or draining so that both full and empty
        // are reached often; small priority ranges force many ties.
        sent = 0;
        while (sent < N_RANDOM) begin
            kind     = $urandom_range(0, 2);
            len      = $urandom_range(10, 50);
            no_idle  = ($urandom_range(0, 3) == 0);
            push_pct = (kind == 0) ? 85 : (kind == 1) ? 15 : 50;
            repeat (len) begin
                mode = ($urandom_range(0, 99) < push_pct) ? MODE_PUSH : MODE_POP;
                v    = VALUE_W'($urandom);
                if ($urandom_range(0, 1) == 1)
                    p = PRIO_IN_W'($urandom_range(0, 6) - 3);
                else
                    p = PRIO_IN_W'($urandom);
                send_request(mode, v, p);
                sent++;
            end
        end
        req_if.valid <= 1'b0;

        no_idle = 1'b1;
        while (sb.pending_results.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
